// ----- src/gsht_pkg.sv -----
`timescale 1ns / 1ps

package gsht_pkg;

   localparam int SLOTS_DEF    = 128;
   localparam int GEN_BITS_DEF = 24;

   localparam int FUNC_W   = 3;
   localparam int HANDLE_W = 31;
   localparam int STATUS_W = 2;
   localparam int SSTATE_W = 2;

   typedef enum logic [FUNC_W-1:0] {
      FN_ALLOC   = 3'd0,
      FN_KILL    = 3'd1,
      FN_PLAY    = 3'd2,
      FN_PAUSE   = 3'd3,
      FN_QUERY   = 3'd4,
      FN_DISPOSE = 3'd5
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 2'd0,
      ST_INVALID = 2'd1,
      ST_FULL    = 2'd2
   } status_type;

   typedef enum logic [SSTATE_W-1:0] {
      SS_DEAD    = 2'd0,
      SS_PAUSED  = 2'd1,
      SS_PLAYING = 2'd2
   } sstate_type;

endpackage

// ----- src/generational_slot_handle_table.sv -----
`timescale 1ns / 1ps

// Slot table that hands out generation-tagged handles (handle = generation * SLOTS + slot).
// Slot state (active bit, playing bit, generation) lives in one single-port-read RAM.
// After reset the table clears every RAM slot with req_ready low.
// Kill, play, pause and query split the handle with a reciprocal multiply and a
// subtract. Allocate scans slots one per RAM read and stops at the lowest free
// one or, when the table is full, after the last slot; dispose walks every slot.
// Unused func codes answer directly. The slot walk sets the longest word time.
// One word is in flight at a time; a finished response waits in the output register
// while the next word is accepted.
module generational_slot_handle_table #(
   parameter int SLOTS    = gsht_pkg::SLOTS_DEF,
   parameter int GEN_BITS = gsht_pkg::GEN_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [gsht_pkg::FUNC_W-1:0]   req_func,
   input  logic [gsht_pkg::HANDLE_W-1:0] req_handle,
   input  logic                          req_autoplay,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [gsht_pkg::STATUS_W-1:0] rsp_status,
   output logic [gsht_pkg::HANDLE_W-1:0] rsp_new_handle,
   output logic [gsht_pkg::SSTATE_W-1:0] rsp_stream_state
);

   localparam int SLOT_W = $clog2(SLOTS);
   localparam int WORD_W = GEN_BITS + 2;

   logic                          mem_rd_en;
   logic [SLOT_W-1:0]             mem_rd_addr;
   logic [WORD_W-1:0]             mem_rd_data;
   logic                          mem_wr_en;
   logic [SLOT_W-1:0]             mem_wr_addr;
   logic [WORD_W-1:0]             mem_wr_data;
   logic                          div_start;
   logic                          div_done;
   logic [gsht_pkg::HANDLE_W-1:0] div_quo;
   logic [SLOT_W-1:0]             div_rem;

   gsht_ram #(
      .DEPTH  (SLOTS),
      .WORD_W (WORD_W),
      .ADDR_W (SLOT_W)
   ) u_ram (
      .clock      (clock),
      .rd_en      (mem_rd_en),
      .rd_addr    (mem_rd_addr),
      .rd_data_ff (mem_rd_data),
      .wr_en      (mem_wr_en),
      .wr_addr    (mem_wr_addr),
      .wr_data    (mem_wr_data)
   );

   gsht_div #(
      .DIVISOR (SLOTS),
      .REM_W   (SLOT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (req_handle),
      .done_ff  (div_done),
      .quo_ff   (div_quo),
      .rem_ff   (div_rem)
   );

   gsht_seq #(
      .SLOTS    (SLOTS),
      .GEN_BITS (GEN_BITS),
      .SLOT_W   (SLOT_W),
      .WORD_W   (WORD_W)
   ) u_seq (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_func          (req_func),
      .req_handle        (req_handle),
      .req_autoplay      (req_autoplay),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_new_handle    (rsp_new_handle),
      .rsp_stream_state  (rsp_stream_state),
      .mem_rd_en         (mem_rd_en),
      .mem_rd_addr       (mem_rd_addr),
      .mem_rd_data       (mem_rd_data),
      .mem_wr_en         (mem_wr_en),
      .mem_wr_addr       (mem_wr_addr),
      .mem_wr_data       (mem_wr_data),
      .div_start         (div_start),
      .div_done          (div_done),
      .div_quo           (div_quo),
      .div_rem           (div_rem)
   );

endmodule

// ----- src/gsht_ram.sv -----
`timescale 1ns / 1ps

module gsht_ram #(
   parameter int DEPTH  = gsht_pkg::SLOTS_DEF,
   parameter int WORD_W = gsht_pkg::GEN_BITS_DEF + 2,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WORD_W-1:0] rd_data_ff,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WORD_W-1:0] wr_data
);

   logic [WORD_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

// ----- src/gsht_div.sv -----
`timescale 1ns / 1ps

// split a handle by a fixed divisor: multiply by a scaled reciprocal, then subtract back
// start latches the dividend, then the quotient is registered, then the remainder and done
module gsht_div #(
   parameter int DIVISOR = gsht_pkg::SLOTS_DEF,
   parameter int REM_W   = $clog2(DIVISOR)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [gsht_pkg::HANDLE_W-1:0] dividend,
   output logic                          done_ff,
   output logic [gsht_pkg::HANDLE_W-1:0] quo_ff,
   output logic [REM_W-1:0]              rem_ff
);

   localparam int HW     = gsht_pkg::HANDLE_W;
   // reciprocal rounded up, exact for every HW-bit dividend
   localparam int SHIFT  = HW + $clog2(DIVISOR);
   localparam int RCP_W  = HW + 2;
   localparam int PROD_W = HW + RCP_W;
   localparam longint unsigned RCP_VAL =
      ((longint'(1) << SHIFT) + longint'(DIVISOR) - longint'(1)) / longint'(DIVISOR);
   localparam logic [RCP_W-1:0] RCP   = RCP_W'(RCP_VAL);
   localparam logic [HW-1:0]    DIV_H = HW'(DIVISOR);

   logic              mul_ff, mul_in;
   logic              sub_ff, sub_in;
   logic              done_in;
   logic [HW-1:0]     num_ff, num_in;
   logic [HW-1:0]     quo_in;
   logic [REM_W-1:0]  rem_in;
   logic [PROD_W-1:0] prod;

   always_comb begin
      prod    = PROD_W'(num_ff) * PROD_W'(RCP);
      mul_in  = start;
      sub_in  = mul_ff;
      done_in = sub_ff;
      num_in  = start ? dividend : num_ff;
      quo_in  = mul_ff ? HW'(prod >> SHIFT) : quo_ff;
      rem_in  = sub_ff ? REM_W'(num_ff - quo_ff * DIV_H) : rem_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_ff  <= 1'b0;
         sub_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         mul_ff  <= mul_in;
         sub_ff  <= sub_in;
         done_ff <= done_in;
      end
      num_ff <= num_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

endmodule

// ----- src/gsht_seq.sv -----
`timescale 1ns / 1ps

module gsht_seq #(
   parameter int SLOTS    = gsht_pkg::SLOTS_DEF,
   parameter int GEN_BITS = gsht_pkg::GEN_BITS_DEF,
   parameter int SLOT_W   = $clog2(SLOTS),
   parameter int WORD_W   = GEN_BITS + 2
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [gsht_pkg::FUNC_W-1:0]   req_func,
   input  logic [gsht_pkg::HANDLE_W-1:0] req_handle,
   input  logic                          req_autoplay,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [gsht_pkg::STATUS_W-1:0] rsp_status,
   output logic [gsht_pkg::HANDLE_W-1:0] rsp_new_handle,
   output logic [gsht_pkg::SSTATE_W-1:0] rsp_stream_state,
   output logic                          mem_rd_en,
   output logic [SLOT_W-1:0]             mem_rd_addr,
   input  logic [WORD_W-1:0]             mem_rd_data,
   output logic                          mem_wr_en,
   output logic [SLOT_W-1:0]             mem_wr_addr,
   output logic [WORD_W-1:0]             mem_wr_data,
   output logic                          div_start,
   input  logic                          div_done,
   input  logic [gsht_pkg::HANDLE_W-1:0] div_quo,
   input  logic [SLOT_W-1:0]             div_rem
);

   localparam int HW    = gsht_pkg::HANDLE_W;
   localparam int CMP_W = (HW > GEN_BITS) ? HW : GEN_BITS;
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);
   localparam logic [HW-1:0]     SLOTS_H   = HW'(SLOTS);

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_DIV, S_EXEC, S_SCAN, S_DISP, S_MUL, S_DONE
   } state_type;

   state_type               state_ff, state_in;
   logic [SLOT_W-1:0]       cnt_ff, cnt_in;
   logic [gsht_pkg::FUNC_W-1:0] func_ff, func_in;
   logic                    autoplay_ff, autoplay_in;
   logic                    hnz_ff, hnz_in;
   logic [GEN_BITS-1:0]     gen_ff, gen_in;
   gsht_pkg::status_type    res_status_ff, res_status_in;
   logic [HW-1:0]           res_handle_ff, res_handle_in;
   gsht_pkg::sstate_type    res_state_ff, res_state_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   gsht_pkg::status_type    rsp_status_ff, rsp_status_in;
   logic [HW-1:0]           rsp_handle_ff, rsp_handle_in;
   gsht_pkg::sstate_type    rsp_state_ff, rsp_state_in;

   logic                    rd_active;
   logic                    rd_playing;
   logic [GEN_BITS-1:0]     rd_gen;
   logic [GEN_BITS-1:0]     gen_next;
   logic                    handle_ok;

   assign rd_active  = mem_rd_data[GEN_BITS+1];
   assign rd_playing = mem_rd_data[GEN_BITS];
   assign rd_gen     = mem_rd_data[GEN_BITS-1:0];
   // generation wraps from all ones to one, never to zero
   assign gen_next   = (rd_gen == '1) ? GEN_BITS'(1) : rd_gen + GEN_BITS'(1);
   assign handle_ok  = hnz_ff && (CMP_W'(div_quo) == CMP_W'(rd_gen));

   assign req_ready        = (state_ff == S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_new_handle   = rsp_handle_ff;
   assign rsp_stream_state = rsp_state_ff;

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      func_in       = func_ff;
      autoplay_in   = autoplay_ff;
      hnz_in        = hnz_ff;
      gen_in        = gen_ff;
      res_status_in = res_status_ff;
      res_handle_in = res_handle_ff;
      res_state_in  = res_state_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_handle_in = rsp_handle_ff;
      rsp_state_in  = rsp_state_ff;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = cnt_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = cnt_ff;
      mem_wr_data   = '0;
      div_start     = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_CLEAR: begin
            // zero every slot after reset
            mem_wr_en = 1'b1;
            cnt_in    = cnt_ff + SLOT_W'(1);
            if (cnt_ff == LAST_SLOT) begin
               cnt_in   = '0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               func_in       = req_func;
               autoplay_in   = req_autoplay;
               hnz_in        = (req_handle != '0);
               res_status_in = gsht_pkg::ST_OK;
               res_handle_in = '0;
               res_state_in  = gsht_pkg::SS_DEAD;
               cnt_in        = '0;
               case (req_func)
                  gsht_pkg::FN_ALLOC: begin
                     mem_rd_en   = 1'b1;
                     mem_rd_addr = '0;
                     state_in    = S_SCAN;
                  end
                  gsht_pkg::FN_KILL, gsht_pkg::FN_PLAY, gsht_pkg::FN_PAUSE,
                  gsht_pkg::FN_QUERY: begin
                     div_start = 1'b1;
                     state_in  = S_DIV;
                  end
                  gsht_pkg::FN_DISPOSE: begin
                     mem_rd_en   = 1'b1;
                     mem_rd_addr = '0;
                     state_in    = S_DISP;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_DIV: begin
            if (div_done) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = div_rem;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            mem_wr_addr = div_rem;
            if (!handle_ok) begin
               res_status_in = gsht_pkg::ST_INVALID;
            end
            case (func_ff)
               gsht_pkg::FN_KILL: begin
                  mem_wr_en   = handle_ok;
                  mem_wr_data = {1'b0, rd_playing, rd_gen};
               end
               gsht_pkg::FN_PLAY: begin
                  mem_wr_en   = handle_ok;
                  mem_wr_data = {rd_active, 1'b1, rd_gen};
               end
               gsht_pkg::FN_PAUSE: begin
                  mem_wr_en   = handle_ok;
                  mem_wr_data = {rd_active, 1'b0, rd_gen};
               end
               gsht_pkg::FN_QUERY: begin
                  if (handle_ok && rd_active) begin
                     res_state_in = rd_playing ? gsht_pkg::SS_PLAYING : gsht_pkg::SS_PAUSED;
                  end
               end
               default: begin
               end
            endcase
            state_in = S_DONE;
         end
         S_SCAN: begin
            // read data belongs to slot cnt_ff
            if (!rd_active) begin
               mem_wr_en   = 1'b1;
               mem_wr_data = {1'b1, autoplay_ff, gen_next};
               gen_in      = gen_next;
               state_in    = S_MUL;
            end else if (cnt_ff == LAST_SLOT) begin
               res_status_in = gsht_pkg::ST_FULL;
               state_in      = S_DONE;
            end else begin
               cnt_in      = cnt_ff + SLOT_W'(1);
               mem_rd_en   = 1'b1;
               mem_rd_addr = cnt_ff + SLOT_W'(1);
            end
         end
         S_MUL: begin
            // handle keeps only its low bits
            res_handle_in = HW'(gen_ff) * SLOTS_H + HW'(cnt_ff);
            state_in      = S_DONE;
         end
         S_DISP: begin
            if (!rd_active) begin
               mem_wr_en   = 1'b1;
               mem_wr_data = {1'b0, rd_playing, GEN_BITS'(0)};
            end
            if (cnt_ff == LAST_SLOT) begin
               state_in = S_DONE;
            end else begin
               cnt_in      = cnt_ff + SLOT_W'(1);
               mem_rd_en   = 1'b1;
               mem_rd_addr = cnt_ff + SLOT_W'(1);
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_handle_in = res_handle_ff;
               rsp_state_in  = res_state_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      func_ff       <= func_in;
      autoplay_ff   <= autoplay_in;
      hnz_ff        <= hnz_in;
      gen_ff        <= gen_in;
      res_status_ff <= res_status_in;
      res_handle_ff <= res_handle_in;
      res_state_ff  <= res_state_in;
      rsp_status_ff <= rsp_status_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_state_ff  <= rsp_state_in;
   end

endmodule

// ----- src/gsht_checker.sv -----
`timescale 1ns / 1ps

module gsht_port_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic [gsht_pkg::FUNC_W-1:0]   req_func,
   input logic [gsht_pkg::HANDLE_W-1:0] req_handle,
   input logic                          req_autoplay,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [gsht_pkg::STATUS_W-1:0] rsp_status,
   input logic [gsht_pkg::HANDLE_W-1:0] rsp_new_handle,
   input logic [gsht_pkg::SSTATE_W-1:0] rsp_stream_state
);

   // a stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_new_handle) && $stable(rsp_stream_state))
      else $error("response changed while stalled");

   // one word in flight: busy right after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("accepted a word while busy");

   // failed commands never grant a handle
   a_fail_no_handle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != gsht_pkg::ST_OK |-> rsp_new_handle == '0)
      else $error("handle granted with failing status");

   // a live stream state only comes from a successful query
   a_state_only_query: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stream_state != gsht_pkg::SS_DEAD
         |-> rsp_status == gsht_pkg::ST_OK && rsp_new_handle == '0)
      else $error("stream state on a non-query response");

   // status is always one of the defined codes
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status == gsht_pkg::ST_OK || rsp_status == gsht_pkg::ST_INVALID
         || rsp_status == gsht_pkg::ST_FULL)
      else $error("undefined status code");

endmodule

bind generational_slot_handle_table gsht_port_checker u_gsht_port_checker (.*);
